[design/eswg_pkg.sv]
// Shared types, codes and helper functions for the edge swipe recognizer.
package eswg_pkg;

  typedef enum logic [1:0] {
    REQ_DOWN = 2'd0,
    REQ_MOVE = 2'd1,
    REQ_UP   = 2'd2,
    REQ_TICK = 2'd3
  } req_t;

  localparam logic [1:0] CMD_NONE    = 2'd0;
  localparam logic [1:0] CMD_HOME    = 2'd1;
  localparam logic [1:0] CMD_RECENTS = 2'd2;

  localparam logic [2:0] REG_SCREEN_HEIGHT = 3'd0;
  localparam logic [2:0] REG_EDGE_BAND     = 3'd1;
  localparam logic [2:0] REG_HOME_TRAVEL   = 3'd2;
  localparam logic [2:0] REG_RECENTS_TRAVEL = 3'd3;
  localparam logic [2:0] REG_HOLD_TIME     = 3'd4;
  localparam logic [2:0] REG_COOLDOWN_TIME = 3'd5;

  typedef struct packed {
    logic [15:0] screen_height;
    logic [15:0] edge_band;
    logic [15:0] home_min_travel;
    logic [15:0] recents_min_travel;
    logic [15:0] hold_time_ms;
    logic [15:0] cooldown_time_ms;
  } cfg_t;

  typedef struct packed {
    logic        touch_active;
    logic        already_fired;
    logic        hold_pending;
    logic [15:0] start_x;
    logic [15:0] start_y;
    logic [15:0] latest_x;
    logic [15:0] latest_y;
    logic [31:0] hold_deadline;
    logic [31:0] cooldown_end;
  } state_t;

  typedef struct packed {
    logic [1:0] command;
    logic       hold_armed;
    logic       gesture_active;
  } result_t;

  typedef struct packed {
    logic signed [16:0] dy;  // upward travel, positive when finger moved up
    logic [15:0]        dx;  // magnitude of sideways travel
  } travel_t;

  function automatic travel_t calc_travel(input logic [15:0] sx, input logic [15:0] sy,
                                          input logic [15:0] lx, input logic [15:0] ly);
    travel_t            tr;
    logic signed [16:0] ddx;
    ddx   = $signed({1'b0, lx}) - $signed({1'b0, sx});
    tr.dy = $signed({1'b0, sy}) - $signed({1'b0, ly});
    tr.dx = ddx[16] ? 16'(-ddx) : ddx[15:0];
    return tr;
  endfunction

  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [15:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {17'd0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

endpackage

[design/eswg_step.sv]
// Next-state and result logic for one touch event.
module eswg_step (
  input  eswg_pkg::cfg_t    cfg,
  input  eswg_pkg::state_t  cur,
  input  logic [1:0]        req_type,
  input  logic [31:0]       time_ms,
  input  logic [15:0]       pos_x,
  input  logic [15:0]       pos_y,
  output eswg_pkg::state_t  nxt,
  output eswg_pkg::result_t res
);
  import eswg_pkg::*;

  travel_t            hold_tr;
  travel_t            rel_tr;
  state_t             mid;
  logic               hold_ready;
  logic               recents_hit;
  logic               in_band;
  logic               home_hit;
  logic signed [17:0] band_top;
  logic [1:0]         cmd;
  logic               armed;

  assign hold_tr  = calc_travel(cur.start_x, cur.start_y, cur.latest_x, cur.latest_y);
  assign rel_tr   = calc_travel(cur.start_x, cur.start_y, pos_x, pos_y);
  assign band_top = $signed({2'b00, cfg.screen_height}) - $signed({2'b00, cfg.edge_band});
  assign in_band  = $signed({2'b00, pos_y}) >= band_top;

  assign hold_ready = cur.touch_active && !cur.already_fired && cur.hold_pending &&
                      (time_ms >= cur.hold_deadline);
  assign recents_hit = hold_ready &&
                       ($signed({hold_tr.dy[16], hold_tr.dy}) >=
                        $signed({2'b00, cfg.recents_min_travel})) &&
                       ($signed({2'b00, hold_tr.dx}) <= $signed({hold_tr.dy[16], hold_tr.dy}));
  // dx * 2 <= dy
  assign home_hit = ($signed({rel_tr.dy[16], rel_tr.dy}) >=
                     $signed({2'b00, cfg.home_min_travel})) &&
                    ($signed({1'b0, rel_tr.dx, 1'b0}) <= $signed({rel_tr.dy[16], rel_tr.dy}));

  always_comb begin
    mid = cur;
    if (recents_hit) begin
      mid.already_fired = 1'b1;
      mid.hold_pending  = 1'b0;
      mid.cooldown_end  = sat_add(cur.hold_deadline, cfg.cooldown_time_ms);
    end
  end

  always_comb begin
    nxt   = mid;
    cmd   = recents_hit ? CMD_RECENTS : CMD_NONE;
    armed = 1'b0;
    unique case (req_t'(req_type))
      REQ_DOWN: begin
        if ((time_ms >= mid.cooldown_end) && in_band) begin
          nxt.touch_active  = 1'b1;
          nxt.already_fired = 1'b0;
          nxt.start_x       = pos_x;
          nxt.start_y       = pos_y;
          nxt.latest_x      = pos_x;
          nxt.latest_y      = pos_y;
          nxt.hold_deadline = sat_add(time_ms, cfg.hold_time_ms);
          nxt.hold_pending  = 1'b1;
          armed             = 1'b1;
        end
      end
      REQ_MOVE: begin
        if (mid.touch_active) begin
          nxt.latest_x = pos_x;
          nxt.latest_y = pos_y;
        end
      end
      REQ_UP: begin
        if (mid.touch_active) begin
          nxt.latest_x     = pos_x;
          nxt.latest_y     = pos_y;
          nxt.touch_active = 1'b0;
          nxt.hold_pending = 1'b0;
          if (!mid.already_fired && home_hit) begin
            nxt.cooldown_end = sat_add(time_ms, cfg.cooldown_time_ms);
            cmd              = CMD_HOME;
          end
        end
      end
      REQ_TICK: begin
      end
      default: begin
      end
    endcase
    res.command        = cmd;
    res.hold_armed     = armed;
    res.gesture_active = nxt.touch_active;
  end

endmodule

[design/edge_swipe_gesture_recognizer_core.sv]
// Top level of the bottom-edge swipe recognizer: config, input stage, state, result register.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+------------------------------------------
//   in      | input     | in_valid/in_stall  | in_req_type, in_time_ms, in_pos_x, in_pos_y
//   out     | output    | out_valid/out_stall| out_command, out_hold_armed, out_gesture_active
//   cfg     | input     | cfg_we             | cfg_index, cfg_wdata
//
// One event per cycle while out_stall is low; an event passes the input register, then the
// output register, to out_valid. In the input register eswg_step evaluates it against the
// gesture state; state and result register load together when the staged event retires.
// A stalled result holds in the output register while the input register still takes
// one more event; in_stall rises only when both are full and out_stall is high.
// Synchronous active-low reset clears state and valids and loads the register defaults.
module edge_swipe_gesture_recognizer_core (
  input  logic        clk,
  input  logic        rst_n,
  // config write port
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  // event input
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_req_type,
  input  logic [31:0] in_time_ms,
  input  logic [15:0] in_pos_x,
  input  logic [15:0] in_pos_y,
  // result output
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_command,
  output logic        out_hold_armed,
  output logic        out_gesture_active
);
  import eswg_pkg::*;

  cfg_t        cfg_r;
  state_t      state_r;
  state_t      state_nxt;
  result_t     res_nxt;
  result_t     res_r;

  // input register
  logic        s1_valid_r;
  logic [1:0]  s1_req_r;
  logic [31:0] s1_time_r;
  logic [15:0] s1_x_r;
  logic [15:0] s1_y_r;

  logic        out_valid_r;
  logic        out_load;   // output register free for a new result
  logic        s1_move;    // the staged event retires this cycle
  logic        in_xfer;

  assign out_load = !out_valid_r || !out_stall;
  assign s1_move  = s1_valid_r && out_load;
  assign in_stall = s1_valid_r && !out_load;
  assign in_xfer  = in_valid && !in_stall;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.screen_height      <= 16'd2400;
      cfg_r.edge_band          <= 16'd144;
      cfg_r.home_min_travel    <= 16'd120;
      cfg_r.recents_min_travel <= 16'd40;
      cfg_r.hold_time_ms       <= 16'd350;
      cfg_r.cooldown_time_ms   <= 16'd500;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SCREEN_HEIGHT:  cfg_r.screen_height      <= cfg_wdata;
        REG_EDGE_BAND:      cfg_r.edge_band          <= cfg_wdata;
        REG_HOME_TRAVEL:    cfg_r.home_min_travel    <= cfg_wdata;
        REG_RECENTS_TRAVEL: cfg_r.recents_min_travel <= cfg_wdata;
        REG_HOLD_TIME:      cfg_r.hold_time_ms       <= cfg_wdata;
        REG_COOLDOWN_TIME:  cfg_r.cooldown_time_ms   <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // input stage: payload needs no reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_xfer) begin
      s1_valid_r <= 1'b1;
    end else if (s1_move) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_req_r  <= in_req_type;
      s1_time_r <= in_time_ms;
      s1_x_r    <= in_pos_x;
      s1_y_r    <= in_pos_y;
    end
  end

  eswg_step u_step (
    .cfg      (cfg_r),
    .cur      (state_r),
    .req_type (s1_req_r),
    .time_ms  (s1_time_r),
    .pos_x    (s1_x_r),
    .pos_y    (s1_y_r),
    .nxt      (state_nxt),
    .res      (res_nxt)
  );

  // gesture state advances only when the staged event retires
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (s1_move) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_command        = res_r.command;
  assign out_hold_armed     = res_r.hold_armed;
  assign out_gesture_active = res_r.gesture_active;

  // an armed hold always belongs to a live touch
  a_pending_needs_touch: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.hold_pending |-> state_r.touch_active)
    else $error("hold pending without active touch");

  // a starting down leaves the gesture active
  a_armed_active: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.hold_armed |-> res_r.gesture_active)
    else $error("hold armed but gesture inactive");

  // home fires only on release
  a_home_on_release: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.command == CMD_HOME |-> !res_r.gesture_active && !res_r.hold_armed)
    else $error("home fired while touch still active");

  // a retiring event always lands in the output register
  a_retire_lands: assert property (@(posedge clk) disable iff (!rst_n)
    s1_move |=> out_valid_r)
    else $error("retired event lost");

endmodule

[test/swipe_gesture_checker.sv]
// Checker for the edge swipe recognizer: predicts each result from accepted events and compares.
`timescale 1ns / 1ps
module swipe_gesture_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  in_req_type,
  input  logic [31:0] in_time_ms,
  input  logic [15:0] in_pos_x,
  input  logic [15:0] in_pos_y,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [1:0]  out_command,
  input  logic        out_hold_armed,
  input  logic        out_gesture_active,
  output int          mismatches,
  output int          outstanding
);
  import eswg_pkg::*;

  typedef struct {
    logic [1:0] command;
    logic       hold_armed;
    logic       gesture_active;
  } gesture_result_t;

  // register copies
  logic [15:0] screen_height, edge_band, home_travel, recents_travel;
  logic [15:0] hold_time, cooldown_time;

  // gesture state
  logic        touching, fired, hold_waiting;
  logic [15:0] start_x, start_y, last_x, last_y;
  logic [31:0] hold_deadline, cooldown_end;

  gesture_result_t expected_results[$];

  function automatic logic [31:0] add_clamped(input logic [31:0] a, input logic [15:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {17'd0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  // upward travel is positive when the finger went toward the top
  function automatic int travel_up();
    return int'(start_y) - int'(last_y);
  endfunction

  function automatic int travel_side();
    int d;
    d = int'(last_x) - int'(start_x);
    return d < 0 ? -d : d;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t: %s mismatch, got %0d expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  task automatic write_register(input logic [2:0] idx, input logic [15:0] val);
    case (idx)
      REG_SCREEN_HEIGHT:  screen_height  = val;
      REG_EDGE_BAND:      edge_band      = val;
      REG_HOME_TRAVEL:    home_travel    = val;
      REG_RECENTS_TRAVEL: recents_travel = val;
      REG_HOLD_TIME:      hold_time      = val;
      REG_COOLDOWN_TIME:  cooldown_time  = val;
      default: ;
    endcase
  endtask

  task automatic apply_touch_event(input req_t kind, input logic [31:0] t,
                                   input logic [15:0] x, input logic [15:0] y,
                                   output gesture_result_t res);
    int rise, drift;
    res.command    = CMD_NONE;
    res.hold_armed = 1'b0;

    // a due hold is judged as of its deadline, before the event itself
    if (touching && !fired && hold_waiting && t >= hold_deadline) begin
      rise  = travel_up();
      drift = travel_side();
      if (rise >= int'(recents_travel) && drift <= rise) begin
        fired        = 1'b1;
        hold_waiting = 1'b0;
        cooldown_end = add_clamped(hold_deadline, cooldown_time);
        res.command  = CMD_RECENTS;
      end
    end

    case (kind)
      REQ_DOWN: begin
        // band limit may go below zero, so the compare is signed
        if (t >= cooldown_end && int'(y) >= int'(screen_height) - int'(edge_band)) begin
          touching       = 1'b1;
          fired          = 1'b0;
          start_x        = x;
          start_y        = y;
          last_x         = x;
          last_y         = y;
          hold_deadline  = add_clamped(t, hold_time);
          hold_waiting   = 1'b1;
          res.hold_armed = 1'b1;
        end
      end
      REQ_MOVE: begin
        if (touching) begin
          last_x = x;
          last_y = y;
        end
      end
      REQ_UP: begin
        if (touching) begin
          last_x       = x;
          last_y       = y;
          touching     = 1'b0;
          hold_waiting = 1'b0;
          if (!fired) begin
            rise  = travel_up();
            drift = travel_side();
            if (rise >= int'(home_travel) && drift * 2 <= rise) begin
              cooldown_end = add_clamped(t, cooldown_time);
              res.command  = CMD_HOME;
            end
          end
        end
      end
      default: ;
    endcase
    res.gesture_active = touching;
  endtask

  always @(posedge clk) begin
    gesture_result_t want;
    if (!rst_n) begin
      screen_height  = 16'd2400;
      edge_band      = 16'd144;
      home_travel    = 16'd120;
      recents_travel = 16'd40;
      hold_time      = 16'd350;
      cooldown_time  = 16'd500;
      touching       = 1'b0;
      fired          = 1'b0;
      hold_waiting   = 1'b0;
      start_x        = '0;
      start_y        = '0;
      last_x         = '0;
      last_y         = '0;
      hold_deadline  = '0;
      cooldown_end   = '0;
      expected_results.delete();
    end else begin
      if (cfg_we)
        write_register(cfg_index, cfg_wdata);
      if (in_valid && !in_stall) begin
        apply_touch_event(req_t'(in_req_type), in_time_ms, in_pos_x, in_pos_y, want);
        expected_results.push_back(want);
      end
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result transfer, command", int'(out_command), -1);
        end else begin
          want = expected_results.pop_front();
          if (out_command !== want.command)
            report_mismatch("command", int'(out_command), int'(want.command));
          if (out_hold_armed !== want.hold_armed)
            report_mismatch("hold_armed", int'(out_hold_armed), int'(want.hold_armed));
          if (out_gesture_active !== want.gesture_active)
            report_mismatch("gesture_active", int'(out_gesture_active),
                            int'(want.gesture_active));
        end
      end
    end
    outstanding <= expected_results.size();
  end

endmodule

[test/edge_swipe_gesture_recognizer_core_test.sv]
// Testbench top for the edge swipe recognizer: stimulus, register phases and verdict.
`timescale 1ns / 1ps
module edge_swipe_gesture_recognizer_core_test;
  import eswg_pkg::*;

  localparam int HALF_PERIOD   = 6;
  localparam int SETTLE_CYCLES = 8;          // well past the input and result registers
  localparam int TIME_LIMIT_NS = 5_000_000;  // normal run is a small fraction of this

  // index codes past the last register; writes to them must change nothing
  localparam logic [2:0] REG_SPARE_LO = 3'd6;
  localparam logic [2:0] REG_SPARE_HI = 3'd7;

  logic        clk, rst_n;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_wdata;
  logic        in_valid, in_stall;
  logic [1:0]  in_req_type;
  logic [31:0] in_time_ms;
  logic [15:0] in_pos_x, in_pos_y;
  logic        out_valid, out_stall;
  logic [1:0]  out_command;
  logic        out_hold_armed, out_gesture_active;
  int          mismatches, outstanding;

  // idle rates in percent for the sender and the result receiver
  int send_idle_pct, recv_idle_pct;

  // copies of the programmed registers, used only to aim the stimulus
  int height_q, band_q, home_q, recents_q, hold_q, cooldown_q;

  int clock_ms;     // event timestamp, mostly monotonic in the random part
  int touch_ms;     // timestamp of the latest touchdown
  int events_sent;

  edge_swipe_gesture_recognizer_core dut (.*);

  swipe_gesture_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #HALF_PERIOD clk = ~clk;
  end

  // Receiver side: stall is redrawn every cycle, so stalls land on every
  // phase of the result path; a zero rate gives back-to-back acceptance.
  always @(posedge clk)
    out_stall <= ($urandom_range(99) < recv_idle_pct);

  // Run watchdog: a hung handshake ends the run here.
  initial begin
    #TIME_LIMIT_NS;
    $display("FAIL edge_swipe_gesture_recognizer_core");
    $finish;
  end

  function automatic int clamp16(input int v);
    return v < 0 ? 0 : (v > 65535 ? 65535 : v);
  endfunction

  // a value at a threshold or up to two either side of it
  function automatic int near(input int v);
    int r;
    r = v + int'($urandom_range(4)) - 2;
    return r < 0 ? 0 : r;
  endfunction

  // Upward travel to aim for: around both thresholds, none, slightly
  // downward, the full screen, or anything in between.
  function automatic int pick_rise();
    case ($urandom_range(6))
      0:       return near(recents_q);
      1:       return near(home_q);
      2:       return 0;
      3:       return -int'($urandom_range(50));
      4:       return 65535;
      default: return $urandom_range(home_q + recents_q + 20);
    endcase
  endfunction

  // Sideways travel: straight, at the home limit (half the rise), at the
  // recents limit (equal to the rise), just past it, or wild.
  function automatic int pick_drift(input int rise);
    int r;
    r = rise < 0 ? 0 : rise;
    case ($urandom_range(5))
      0:       return 0;
      1:       return r / 2 + int'($urandom_range(2)) - 1;
      2:       return r;
      3:       return r + 1;
      4:       return $urandom_range(65535);
      default: return $urandom_range(r + 5);
    endcase
  endfunction

  // Time between events of one gesture; one choice lands on or next to the hold deadline.
  function automatic int pick_step();
    int deadline;
    deadline = touch_ms + hold_q;
    case ($urandom_range(4))
      0:       return 0;
      1, 2:    return $urandom_range(hold_q / 3 + 2);
      3:       return deadline > clock_ms ? deadline - clock_ms + int'($urandom_range(2)) - 1 : 1;
      default: return $urandom_range(hold_q + 5);
    endcase
  endfunction

  // Time before a new touchdown, often close to the cooldown.
  function automatic int pick_gap();
    case ($urandom_range(4))
      0:       return 0;
      1:       return near(cooldown_q);
      2:       return $urandom_range(hold_q / 4 + 3);
      default: return $urandom_range(cooldown_q + hold_q + 10);
    endcase
  endfunction

  // One input transfer. Valid goes high after an optional idle stretch and
  // the payload holds until the edge where in_stall is low.
  task automatic send_event(input req_t kind, input logic [31:0] t,
                            input logic [15:0] x, input logic [15:0] y);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_req_type <= kind;
    in_time_ms  <= t;
    in_pos_x    <= x;
    in_pos_y    <= y;
    do @(posedge clk); while (in_stall);
    events_sent++;
  endtask

  // Drop valid and hold off until every predicted result has been seen.
  // The do-while covers an event accepted on the edge just before.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic write_reg(input logic [2:0] idx, input int val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val[15:0];
    @(posedge clk);
  endtask

  // Registers change only with the block idle: all results in, then a settling
  // wait. All six registers plus the two unused indexes are written.
  task automatic program_regs(input int h, input int b, input int hm,
                              input int rc, input int hd, input int cd);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    write_reg(REG_SCREEN_HEIGHT, h);
    write_reg(REG_EDGE_BAND, b);
    write_reg(REG_HOME_TRAVEL, hm);
    write_reg(REG_RECENTS_TRAVEL, rc);
    write_reg(REG_HOLD_TIME, hd);
    write_reg(REG_COOLDOWN_TIME, cd);
    write_reg(REG_SPARE_LO, $urandom_range(65535));
    write_reg(REG_SPARE_HI, $urandom_range(65535));
    cfg_we     <= 1'b0;
    height_q   = h;
    band_q     = b;
    home_q     = hm;
    recents_q  = rc;
    hold_q     = hd;
    cooldown_q = cd;
  endtask

  // A well-formed attempt: touchdown mostly inside the band, a few moves
  // and ticks with travel aimed at the thresholds, then usually a release.
  // Some attempts end in a stray move (abandoned) or a fresh down (restart).
  task automatic swipe_attempt();
    int   lo, sx, sy, lx, ly, rise, drift, moves;
    req_t kind;
    lo = height_q - band_q;
    clock_ms += pick_gap();
    case ($urandom_range(19))
      0, 1:    sy = clamp16(lo - 1);
      2, 3, 4: sy = $urandom_range(lo < 0 ? 0 : lo, 65535);
      5, 6, 7: sy = 65535;
      default: sy = clamp16(lo + int'($urandom_range(band_q)));
    endcase
    sx = $urandom_range(65535);
    touch_ms = clock_ms;
    send_event(REQ_DOWN, clock_ms, 16'(sx), 16'(sy));
    moves = $urandom_range(5);
    for (int i = 0; i <= moves; i++) begin
      rise  = pick_rise();
      drift = pick_drift(rise);
      lx    = clamp16($urandom_range(1) ? sx + drift : sx - drift);
      ly    = clamp16(sy - rise);
      clock_ms += pick_step();
      if (i < moves)
        kind = ($urandom_range(4) == 0) ? REQ_TICK : REQ_MOVE;
      else
        case ($urandom_range(9))
          0:       kind = REQ_MOVE;
          1:       kind = REQ_DOWN;
          default: kind = REQ_UP;
        endcase
      send_event(kind, clock_ms, 16'(lx), 16'(ly));
    end
  endtask

  // Noise: any kind anywhere, now and then with the clock stepping back.
  task automatic noise_event();
    int t;
    clock_ms += $urandom_range(20);
    t = ($urandom_range(7) == 0 && clock_ms > 100) ? clock_ms - int'($urandom_range(1, 100))
                                                   : clock_ms;
    send_event(req_t'($urandom_range(3)), t, 16'($urandom_range(65535)),
               16'($urandom_range(65535)));
  endtask

  // One register setting's worth of random traffic. Halfway through, the
  // sender holds off until the pipeline has emptied.
  task automatic run_phase(input int count);
    int target;
    bit drained;
    target  = events_sent + count;
    drained = 1'b0;
    while (events_sent < target) begin
      if (!drained && events_sent >= target - count / 2) begin
        wait_drained();
        drained = 1'b1;
      end
      if ($urandom_range(4) == 0)
        noise_event();
      else
        swipe_attempt();
    end
  endtask

  initial begin
    // every input known from time zero; reset held low before release
    rst_n       <= 1'b0;
    cfg_we      <= 1'b0;
    cfg_index   <= REG_SCREEN_HEIGHT;
    cfg_wdata   <= '0;
    in_valid    <= 1'b0;
    in_req_type <= REQ_TICK;
    in_time_ms  <= '0;
    in_pos_x    <= '0;
    in_pos_y    <= '0;
    out_stall   <= 1'b0;
    events_sent = 0;
    send_idle_pct = 32;
    recv_idle_pct = 71;
    height_q = 2400;  band_q = 144;  home_q = 120;
    recents_q = 40;   hold_q = 350;  cooldown_q = 500;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part at reset values: band starts at row 2256.
    // Tick, move and release with no gesture do nothing.
    send_event(REQ_TICK, 0, 0, 0);
    send_event(REQ_MOVE, 0, 16'hFFFF, 16'hFFFF);
    send_event(REQ_UP, 1, 5, 5);
    // touchdown at time zero on the lowest row; hold deadline 350
    send_event(REQ_DOWN, 0, 0, 16'hFFFF);
    send_event(REQ_MOVE, 10, 40, 16'hFFFF - 50);
    send_event(REQ_TICK, 349, 0, 0);                 // one short of the deadline
    send_event(REQ_TICK, 350, 0, 0);                 // recents, cooldown to 850
    send_event(REQ_UP, 400, 40, 16'hFFFF - 50);      // already fired, no home
    send_event(REQ_DOWN, 849, 10, 2300);             // inside cooldown
    // band edge row, right edge column; rise 120 with drift 60 meets home exactly
    send_event(REQ_DOWN, 850, 16'hFFFF, 2256);
    send_event(REQ_MOVE, 860, 16'hFFFF - 60, 2136);
    send_event(REQ_UP, 900, 16'hFFFF - 60, 2136);    // home, cooldown to 1400
    send_event(REQ_DOWN, 1400, 100, 2255);           // one row above the band
    send_event(REQ_DOWN, 1400, 100, 3000);           // starts, deadline 1750
    send_event(REQ_DOWN, 1500, 200, 2500);           // restarts, deadline 1850
    send_event(REQ_MOVE, 1600, 200, 2470);           // rise 30, short of recents
    send_event(REQ_TICK, 1900, 0, 0);                // due but not met, stays armed
    send_event(REQ_MOVE, 1950, 350, 2400);           // rise 100, drift 150
    send_event(REQ_MOVE, 1990, 250, 2400);           // still judged on drift 150
    send_event(REQ_TICK, 2001, 0, 0);                // recents as of 1850
    send_event(REQ_UP, 2010, 250, 2400);
    // finger slides down: negative rise never fires home
    send_event(REQ_DOWN, 2400, 5, 2300);
    send_event(REQ_MOVE, 2410, 5, 2350);
    send_event(REQ_UP, 2420, 5, 2350);

    clock_ms = 5000;

    // first stage: sender idles lightly, receiver heavily
    program_regs(2400, 144, 120, 40, 350, 500);
    run_phase(258);
    // all registers at zero: whole screen is band, instant hold, no cooldown
    program_regs(0, 0, 0, 0, 0, 0);
    run_phase(258);

    // second stage: idle rates swapped
    send_idle_pct = 71;
    recv_idle_pct = 32;
    // band taller than the screen, all travel and times at maximum
    program_regs(100, 300, 65535, 65535, 65535, 65535);
    run_phase(258);
    // two-row band at the bottom, tiny home travel, short times
    program_regs(65535, 1, 1, 65535, 1, 10);
    run_phase(258);

    // third stage: back-to-back on both sides
    send_idle_pct = 0;
    recv_idle_pct = 0;
    program_regs(1000, 200, 300, 100, 50, 80);
    run_phase(258);
    program_regs(2400, 2400, 120, 40, 350, 500);
    run_phase(250);

    // Timestamps at the top of the range: deadline and cooldown saturate.
    // Kept last since a saturated cooldown blocks every later touchdown stamped below the maximum.
    send_event(REQ_DOWN, 32'hFFFF_FF00, 16'h1234, 16'hFFFF);
    send_event(REQ_MOVE, 32'hFFFF_FF10, 16'h1234, 16'hFFFF - 200);
    send_event(REQ_UP, 32'hFFFF_FFF0, 16'h1234, 16'hFFFF - 200);
    send_event(REQ_DOWN, 32'hFFFF_FFFE, 0, 0);
    send_event(REQ_DOWN, 32'hFFFF_FFFF, 0, 16'hFFFF);
    send_event(REQ_MOVE, 32'hFFFF_FFFF, 0, 16'hFFFF - 40);
    send_event(REQ_TICK, 32'hFFFF_FFFF, 0, 0);

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && outstanding == 0)
      $display("PASS edge_swipe_gesture_recognizer_core");
    else
      $display("FAIL edge_swipe_gesture_recognizer_core");
    $finish;
  end

endmodule
